>>> rtl/swk_pkg.sv
// Shared types and constants for the swerve drive wheel kinematics block.
// Holds the request structs, sequencer states, register indexes and the CORDIC
// arctangent table. No dependencies.
package swk_pkg;

  typedef struct packed {
    logic signed [15:0] target_vx;
    logic signed [15:0] target_vy;
    logic signed [15:0] target_turn_rate;
    logic        [15:0] heading;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] speed_front_left;
    logic signed [15:0] speed_front_right;
    logic signed [15:0] speed_back_left;
    logic signed [15:0] speed_back_right;
    logic signed [31:0] steer_front_left;
    logic signed [31:0] steer_front_right;
    logic signed [31:0] steer_back_left;
    logic signed [31:0] steer_back_right;
  } out_item_t;

  // Start command for the shared CORDIC unit
  typedef struct packed {
    logic start;
    logic rotate;
  } cordic_req_t;

  // Configuration register indexes
  localparam logic [3:0] CFG_MAX_LIN   = 4'd0;
  localparam logic [3:0] CFG_MAX_TURN  = 4'd1;
  localparam logic [3:0] CFG_RADIUS    = 4'd2;
  localparam logic [3:0] CFG_RPM_GAIN  = 4'd3;

  // Angles inside the CORDIC: 2^32 units per turn, 33-bit signed
  localparam logic signed [32:0] HALF_TURN    = 33'sh080000000;
  localparam logic signed [32:0] QUARTER_TURN = 33'sh040000000;

  // CORDIC gain removal (Q16) and turn coefficient pi/180*sqrt(2)/2 (Q24) applied to w*R
  localparam logic signed [32:0] INV_GAIN_Q16  = 33'sd39797;
  localparam logic signed [32:0] TURN_COEF_Q24 = 33'sd207053;

  typedef enum logic [28:0] {
    ST_IDLE = 29'h0000001,
    ST_SQX  = 29'h0000002,
    ST_SQY  = 29'h0000004,
    ST_SQM  = 29'h0000008,
    ST_CMP  = 29'h0000010,
    ST_LEN  = 29'h0000020,
    ST_MULX = 29'h0000040,
    ST_DSX  = 29'h0000080,
    ST_DIVX = 29'h0000100,
    ST_MULY = 29'h0000200,
    ST_DSY  = 29'h0000400,
    ST_DIVY = 29'h0000800,
    ST_ROT  = 29'h0001000,
    ST_ROTW = 29'h0002000,
    ST_GX   = 29'h0004000,
    ST_GY   = 29'h0008000,
    ST_WR   = 29'h0010000,
    ST_WRK  = 29'h0020000,
    ST_TT   = 29'h0040000,
    ST_MV   = 29'h0080000,
    ST_MX   = 29'h0100000,
    ST_MY   = 29'h0200000,
    ST_MS   = 29'h0400000,
    ST_MZ   = 29'h0800000,
    ST_MQ   = 29'h1000000,
    ST_MG   = 29'h2000000,
    ST_MC   = 29'h4000000,
    ST_MW   = 29'h8000000,
    ST_DONE = 29'h10000000
  } state_t;

  // Arctangent of 2^-i in 2^32 units per turn
  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] a;
    unique case (i)
      5'd0:  a = 32'd536870912;
      5'd1:  a = 32'd316933406;
      5'd2:  a = 32'd167458907;
      5'd3:  a = 32'd85004756;
      5'd4:  a = 32'd42667331;
      5'd5:  a = 32'd21354465;
      5'd6:  a = 32'd10680862;
      5'd7:  a = 32'd5340245;
      5'd8:  a = 32'd2670163;
      5'd9:  a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;
      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2608;
      5'd19: a = 32'd1304;
      5'd20: a = 32'd652;
      5'd21: a = 32'd326;
      5'd22: a = 32'd163;
      5'd23: a = 32'd81;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

>>> rtl/swk_cordic.sv
// Iterative CORDIC unit, one micro-rotation per cycle, rotation or vectoring.
// Depends on swk_pkg for the arctangent table and angle constants.
module swk_cordic import swk_pkg::*; #(
  parameter int STEPS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cordic_req_t        req,
  input  logic signed [49:0] x0,
  input  logic signed [49:0] y0,
  input  logic signed [32:0] z0,
  output logic signed [49:0] x,
  output logic signed [49:0] y,
  output logic signed [32:0] z,
  output logic               done
);

  localparam int N  = (STEPS > 24) ? 24 : STEPS;
  localparam int IW = (N > 1) ? $clog2(N) : 1;

  logic signed [49:0] x_r, y_r, xa, ya, xs, ys;
  logic signed [32:0] z_r, za, at;
  logic [IW-1:0]      i_r;
  logic               busy_r, done_r, rot_r, pos;

  // Fold the start vector into the convergence range
  always_comb begin
    xa = x0;
    ya = y0;
    za = z0;
    if (req.rotate) begin
      if (z0 > QUARTER_TURN) begin
        xa = -x0;
        ya = -y0;
        za = z0 - HALF_TURN;
      end else if (z0 < -QUARTER_TURN) begin
        xa = -x0;
        ya = -y0;
        za = z0 + HALF_TURN;
      end
    end else if (x0 < 0) begin
      xa = -x0;
      ya = -y0;
      za = HALF_TURN;
    end else begin
      za = '0;
    end
  end

  // One micro-rotation
  always_comb begin
    xs  = x_r >>> i_r;
    ys  = y_r >>> i_r;
    at  = $signed({1'b0, atan_lut(5'(i_r))});
    pos = rot_r ? !z_r[32] : !(y_r > 0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        i_r    <= '0;
      end else if (busy_r) begin
        i_r <= i_r + 1'b1;
        if (i_r == IW'(N - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      x_r   <= xa;
      y_r   <= ya;
      z_r   <= za;
      rot_r <= req.rotate;
    end else if (busy_r) begin
      if (pos) begin
        x_r <= x_r - ys;
        y_r <= y_r + xs;
        z_r <= z_r - at;
      end else begin
        x_r <= x_r + ys;
        y_r <= y_r - xs;
        z_r <= z_r + at;
      end
    end
  end

  assign x    = x_r;
  assign y    = y_r;
  assign z    = z_r;
  assign done = done_r;

endmodule

>>> rtl/swk_isqrt.sv
// Digit-by-digit integer square root, one result bit per cycle.
// Floor square root of a 64-bit value. Uses swk_pkg.
module swk_isqrt import swk_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] value,
  output logic [31:0] root,
  output logic        done
);

  logic [63:0] v_r;
  logic [33:0] rem_r;
  logic [31:0] root_r;
  logic [4:0]  cnt_r;
  logic        busy_r, done_r, ge;
  logic [35:0] cat, trial, diff;

  always_comb begin
    cat   = {rem_r, v_r[63:62]};
    trial = {2'b00, root_r, 2'b01};
    ge    = cat >= trial;
    diff  = cat - trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Bring down two bits, try the next root bit
  always_ff @(posedge clk) begin
    if (start) begin
      v_r    <= value;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      v_r    <= {v_r[61:0], 2'b00};
      rem_r  <= ge ? diff[33:0] : cat[33:0];
      root_r <= {root_r[30:0], ge};
    end
  end

  assign root = root_r;
  assign done = done_r;

endmodule

>>> rtl/swk_div.sv
// Restoring divider, one quotient bit per cycle, truncating toward zero.
// Signed 32-bit dividend by a nonzero 16-bit divisor. Uses swk_pkg.
module swk_div import swk_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic        [15:0] den,
  output logic signed [16:0] quot,
  output logic               done
);

  logic [31:0] q_r;
  logic [15:0] rem_r, d_r;
  logic [4:0]  cnt_r;
  logic        neg_r, busy_r, done_r, ge;
  logic [16:0] try_v, sub_v;

  always_comb begin
    try_v = {rem_r, q_r[31]};
    ge    = try_v >= {1'b0, d_r};
    sub_v = try_v - {1'b0, d_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Shift the magnitude through the partial remainder
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= num[31];
      q_r   <= num[31] ? 32'(-num) : 32'(num);
      d_r   <= den;
      rem_r <= '0;
    end else if (busy_r) begin
      rem_r <= ge ? sub_v[15:0] : try_v[15:0];
      q_r   <= {q_r[30:0], ge};
    end
  end

  assign quot = neg_r ? -$signed(q_r[16:0]) : $signed(q_r[16:0]);
  assign done = done_r;

endmodule

>>> rtl/swerve_drive_wheel_kinematics.sv
// Four-wheel swerve drive inverse kinematics on one shared CORDIC, square root
// and divider. Depends on swk_pkg, swk_cordic, swk_isqrt and swk_div.
//
// One request is processed at a time: in_ready is high only while the sequencer
// is idle, and a finished result sits in the output register so the next request
// can be taken while it waits. Each request runs the frame rotation on the CORDIC,
// then per wheel one square root and one CORDIC vectoring; when the linear speed
// limit applies it first runs one more square root and two divisions. A wheel
// whose vector is zero, or any wheel when the gain is zero, skips its square root
// and CORDIC. A finished request waits in the sequencer until the output register
// is free. Configuration writes are always accepted and take effect at once, so
// write them only while no request is in flight.
module swerve_drive_wheel_kinematics import swk_pkg::*; #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  state_t state_r, state_nxt;

  logic [15:0] max_lin_r, max_turn_r, gain_r;
  logic [11:0] radius_r;

  logic signed [16:0] vx_r, vy_r, w_r, wmax;
  logic [15:0]        hd_r, len_r;
  logic [63:0]        acc_r;
  logic signed [30:0] rx_r, ry_r, t_r, mx_r, my_r;
  logic [31:0]        mag_r;
  logic signed [15:0] rpm_r;
  logic [1:0]         m_r;
  logic [31:0]        st_r [4];
  logic signed [15:0] spd_r [4];
  logic               out_valid_r, out_free, lim, wheel_on;
  out_item_t          out_r;

  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p_r, rnd;

  cordic_req_t        cor_req;
  logic signed [49:0] cor_x0, cor_y0, cor_x, cor_y;
  logic signed [32:0] cor_z0, cor_z, cz_rnd;
  logic               cor_done;
  logic [31:0]        zrot;

  logic               sq_start, sq_done;
  logic [31:0]        sq_root;
  logic               dv_start, dv_done;
  logic signed [16:0] dv_q;

  logic signed [15:0] target;
  logic [31:0]        dsum, st_new;

  assign in_ready  = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || out_ready;

  assign lim      = acc_r > {32'd0, mul_p_r[31:0]};
  assign wheel_on = (mx_r != '0 || my_r != '0) && gain_r != '0;
  assign wmax     = $signed({1'b0, max_turn_r});
  assign rnd      = (mul_p_r + 66'sd32768) >>> 16;

  // Steering target and nearest half-turn equivalent
  assign cz_rnd = cor_z + 33'sd32768;
  assign target = cz_rnd[31:16];
  assign dsum   = {{16{target[15]}}, target} - st_r[m_r] + 32'd16384;
  assign st_new = st_r[m_r] + {17'd0, dsum[14:0]} - 32'd16384;

  // Shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_SQX: begin
        mul_a = 33'(vx_r);
        mul_b = 33'(vx_r);
      end
      ST_SQY: begin
        mul_a = 33'(vy_r);
        mul_b = 33'(vy_r);
      end
      ST_SQM: begin
        mul_a = {17'd0, max_lin_r};
        mul_b = {17'd0, max_lin_r};
      end
      ST_MULX: begin
        mul_a = 33'(vx_r);
        mul_b = {17'd0, max_lin_r};
      end
      ST_MULY: begin
        mul_a = 33'(vy_r);
        mul_b = {17'd0, max_lin_r};
      end
      ST_GX: begin
        mul_a = cor_x[32:0];
        mul_b = INV_GAIN_Q16;
      end
      ST_GY: begin
        mul_a = cor_y[32:0];
        mul_b = INV_GAIN_Q16;
      end
      ST_WR: begin
        mul_a = 33'(w_r);
        mul_b = {21'd0, radius_r};
      end
      ST_WRK: begin
        mul_a = mul_p_r[32:0];
        mul_b = TURN_COEF_Q24;
      end
      ST_MX: begin
        mul_a = 33'(mx_r);
        mul_b = 33'(mx_r);
      end
      ST_MY: begin
        mul_a = 33'(my_r);
        mul_b = 33'(my_r);
      end
      ST_MG: begin
        mul_a = {1'b0, mag_r};
        mul_b = {17'd0, gain_r};
      end
      default: ;
    endcase
  end

  // Shared unit requests
  assign zrot           = 32'd0 - {hd_r, 16'd0};
  assign cor_req.start  = (state_r == ST_ROT) || (state_r == ST_MC);
  assign cor_req.rotate = (state_r == ST_ROT);
  assign cor_x0 = (state_r == ST_ROT) ? {{25{vx_r[16]}}, vx_r, 8'd0}
                                      : {{3{mx_r[30]}}, mx_r, 16'd0};
  assign cor_y0 = (state_r == ST_ROT) ? {{25{vy_r[16]}}, vy_r, 8'd0}
                                      : {{3{my_r[30]}}, my_r, 16'd0};
  assign cor_z0 = (state_r == ST_ROT) ? {zrot[31], zrot} : '0;

  assign sq_start = ((state_r == ST_CMP) && lim) || ((state_r == ST_MZ) && wheel_on);
  assign dv_start = (state_r == ST_DSX) || (state_r == ST_DSY);

  swk_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (cor_req),
    .x0   (cor_x0),
    .y0   (cor_y0),
    .z0   (cor_z0),
    .x    (cor_x),
    .y    (cor_y),
    .z    (cor_z),
    .done (cor_done)
  );

  swk_isqrt u_isqrt (
    .clk  (clk),
    .rst_n(rst_n),
    .start(sq_start),
    .value(acc_r),
    .root (sq_root),
    .done (sq_done)
  );

  swk_div u_div (
    .clk  (clk),
    .rst_n(rst_n),
    .start(dv_start),
    .num  (mul_p_r[31:0]),
    .den  (len_r),
    .quot (dv_q),
    .done (dv_done)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_SQX;
      ST_SQX:  state_nxt = ST_SQY;
      ST_SQY:  state_nxt = ST_SQM;
      ST_SQM:  state_nxt = ST_CMP;
      ST_CMP:  state_nxt = lim ? ST_LEN : ST_ROT;
      ST_LEN:  if (sq_done) state_nxt = ST_MULX;
      ST_MULX: state_nxt = ST_DSX;
      ST_DSX:  state_nxt = ST_DIVX;
      ST_DIVX: if (dv_done) state_nxt = ST_MULY;
      ST_MULY: state_nxt = ST_DSY;
      ST_DSY:  state_nxt = ST_DIVY;
      ST_DIVY: if (dv_done) state_nxt = ST_ROT;
      ST_ROT:  state_nxt = ST_ROTW;
      ST_ROTW: if (cor_done) state_nxt = ST_GX;
      ST_GX:   state_nxt = ST_GY;
      ST_GY:   state_nxt = ST_WR;
      ST_WR:   state_nxt = ST_WRK;
      ST_WRK:  state_nxt = ST_TT;
      ST_TT:   state_nxt = ST_MV;
      ST_MV:   state_nxt = ST_MX;
      ST_MX:   state_nxt = ST_MY;
      ST_MY:   state_nxt = ST_MS;
      ST_MS:   state_nxt = ST_MZ;
      ST_MZ: begin
        if (wheel_on) state_nxt = ST_MQ;
        else          state_nxt = (m_r == 2'd3) ? ST_DONE : ST_MV;
      end
      ST_MQ:   if (sq_done) state_nxt = ST_MG;
      ST_MG:   state_nxt = ST_MC;
      ST_MC:   state_nxt = ST_MW;
      ST_MW:   if (cor_done) state_nxt = (m_r == 2'd3) ? ST_DONE : ST_MV;
      ST_DONE: if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state, configuration and steering store
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      m_r         <= '0;
      out_valid_r <= 1'b0;
      max_lin_r   <= 16'd3000;
      max_turn_r  <= 16'd360;
      radius_r    <= 12'd300;
      gain_r      <= 16'd256;
      for (int i = 0; i < 4; i++) begin
        st_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_MAX_LIN:  max_lin_r  <= cfg_data;
          CFG_MAX_TURN: max_turn_r <= cfg_data;
          CFG_RADIUS:   radius_r   <= cfg_data[11:0];
          CFG_RPM_GAIN: gain_r     <= cfg_data;
          default: ;
        endcase
      end
      if (state_r == ST_TT) begin
        m_r <= '0;
      end else if ((state_r == ST_MZ && !wheel_on) || (state_r == ST_MW && cor_done)) begin
        m_r <= m_r + 1'b1;
      end
      if (state_r == ST_MW && cor_done) begin
        st_r[m_r] <= st_new;
      end
      // Hold the result until taken
      if (state_r == ST_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    mul_p_r <= mul_a * mul_b;
    if (in_valid && in_ready) begin
      vx_r <= 17'(in_data.target_vx);
      vy_r <= 17'(in_data.target_vy);
      w_r  <= 17'(in_data.target_turn_rate);
      hd_r <= in_data.heading;
    end
    unique case (state_r)
      ST_SQX: begin
        if (w_r > wmax)       w_r <= wmax;
        else if (w_r < -wmax) w_r <= -wmax;
      end
      ST_SQY: acc_r <= mul_p_r[63:0];
      ST_SQM: acc_r <= acc_r + mul_p_r[63:0];
      ST_LEN: if (sq_done) len_r <= sq_root[15:0];
      ST_DIVX: if (dv_done) vx_r <= dv_q;
      ST_DIVY: if (dv_done) vy_r <= dv_q;
      ST_GY: rx_r <= rnd[30:0];
      ST_WR: ry_r <= rnd[30:0];
      ST_TT: t_r  <= rnd[30:0];
      ST_MV: begin
        mx_r <= m_r[1] ? rx_r + t_r : rx_r - t_r;
        my_r <= m_r[0] ? ry_r + t_r : ry_r - t_r;
      end
      ST_MY: acc_r <= mul_p_r[63:0];
      ST_MS: acc_r <= acc_r + mul_p_r[63:0];
      ST_MZ: if (!wheel_on) spd_r[m_r] <= '0;
      ST_MQ: if (sq_done) mag_r <= sq_root;
      ST_MC: rpm_r <= (rnd > 66'sd32767) ? 16'sd32767 : rnd[15:0];
      ST_MW: if (cor_done) spd_r[m_r] <= dsum[15] ? -rpm_r : rpm_r;
      ST_DONE: begin
        if (out_free) begin
          out_r.speed_front_left  <= spd_r[0];
          out_r.speed_front_right <= spd_r[1];
          out_r.speed_back_left   <= spd_r[2];
          out_r.speed_back_right  <= spd_r[3];
          out_r.steer_front_left  <= st_r[0];
          out_r.steer_front_right <= st_r[1];
          out_r.steer_back_left   <= st_r[2];
          out_r.steer_back_right  <= st_r[3];
        end
      end
      default: ;
    endcase
  end

  // CORDIC finishes only while the sequencer waits for it
  a_cordic_wait: assert property (@(posedge clk) disable iff (!rst_n)
    cor_done |-> (state_r == ST_ROTW || state_r == ST_MW))
    else $error("CORDIC finished outside a wait state");

  // Square root finishes only while the sequencer waits for it
  a_isqrt_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sq_done |-> (state_r == ST_LEN || state_r == ST_MQ))
    else $error("square root finished outside a wait state");

  // Divider finishes only while the sequencer waits for it
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    dv_done |-> (state_r == ST_DIVX || state_r == ST_DIVY))
    else $error("divider finished outside a wait state");

endmodule

>>> tb/testbench.sv
// Self-checking testbench for swerve_drive_wheel_kinematics.
// Depends on swk_pkg and the block; an in-class model predicts each request's
// wheel speeds and multi-turn steering angles.
module testbench;
  import swk_pkg::*;

  localparam logic [3:0] CFG_UNUSED = 4'd9;
  localparam int RANDOM_PER_PHASE = 290;
  localparam int SETTLE_CYCLES = 500;

  // Predicts wheel commands and holds the ones still owed by the block
  class wheel_scoreboard;
    out_item_t wheel_cmd_q[$];
    int fails = 0;
    longint max_lin = 3000, max_turn = 360, radius = 300, gain = 256;
    logic [31:0] steer[4] = '{default: 32'd0};
    longint atan_t[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10680862, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

    function void set_reg(logic [3:0] idx, logic [15:0] d);
      case (idx)
        CFG_MAX_LIN:  max_lin = d;
        CFG_MAX_TURN: max_turn = d;
        CFG_RADIUS:   radius = d[11:0];
        CFG_RPM_GAIN: gain = d;
        default: ;
      endcase
    endfunction

    function longint unsigned root(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v = v - (r + b);
          r = (r >> 1) + b;
        end else r = r >> 1;
        b = b >> 2;
      end
      return r;
    endfunction

    // Vectoring CORDIC, result rounded to 16-bit angle units
    function longint heading_of(longint x, longint y);
      longint z, dx, dy;
      logic [15:0] a;
      z = 0;
      if (x < 0) begin
        x = -x; y = -y; z = 64'sd2147483648;
      end
      for (int i = 0; i < 16; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y > 0) begin
          x += dx; y -= dy; z += atan_t[i];
        end else begin
          x -= dx; y += dy; z -= atan_t[i];
        end
      end
      a = 16'((z + 32768) >>> 16);
      return longint'(signed'(a));
    endfunction

    function void note_request(in_item_t r);
      longint vx, vy, w, len, x, y, z, dx, dy, rx, ry, t, mx, my, tgt, cur, dlt, k, spd;
      longint unsigned s, mag, rpm;
      logic [31:0] zz, st;
      out_item_t o;
      vx = r.target_vx;
      vy = r.target_vy;
      w = r.target_turn_rate;
      s = longint'(vx * vx) + longint'(vy * vy);
      // Scale the linear command down to the speed limit
      if (s > longint'(max_lin * max_lin)) begin
        len = root(s);
        vx = vx * max_lin / len;
        vy = vy * max_lin / len;
      end
      if (w > max_turn) w = max_turn;
      if (w < -max_turn) w = -max_turn;
      // Rotate into the robot frame by minus the heading
      zz = 32'd0 - {r.heading, 16'd0};
      z = longint'(signed'(zz));
      x = vx * 256;
      y = vy * 256;
      if (z > 64'sd1073741824) begin
        x = -x; y = -y; z -= 64'sd2147483648;
      end else if (z < -64'sd1073741824) begin
        x = -x; y = -y; z += 64'sd2147483648;
      end
      for (int i = 0; i < 16; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (z >= 0) begin
          x -= dx; y += dy; z -= atan_t[i];
        end else begin
          x += dx; y -= dy; z += atan_t[i];
        end
      end
      rx = (x * 39797 + 32768) >>> 16;
      ry = (y * 39797 + 32768) >>> 16;
      t = (w * radius * 207053 + 32768) >>> 16;
      // Per module: vector, speed and nearest steering equivalent
      for (int m = 0; m < 4; m++) begin
        mx = rx + ((m < 2) ? -t : t);
        my = ry + ((m % 2 == 0) ? -t : t);
        st = steer[m];
        spd = 0;
        if ((mx != 0 || my != 0) && gain != 0) begin
          mag = root(longint'(mx * mx) + longint'(my * my));
          rpm = (mag * gain + 32768) >> 16;
          tgt = heading_of(mx * 65536, my * 65536);
          cur = longint'(signed'(st));
          dlt = tgt - cur;
          k = (dlt + 16384) >>> 15;
          st = st + 32'(dlt - k * 32768);
          steer[m] = st;
          if (rpm > 32767) rpm = 32767;
          spd = rpm;
          if (k[0]) spd = -spd;
        end
        case (m)
          0: begin o.speed_front_left = 16'(spd);  o.steer_front_left = st;  end
          1: begin o.speed_front_right = 16'(spd); o.steer_front_right = st; end
          2: begin o.speed_back_left = 16'(spd);   o.steer_back_left = st;   end
          default: begin o.speed_back_right = 16'(spd); o.steer_back_right = st; end
        endcase
      end
      wheel_cmd_q.push_back(o);
    endfunction

    function void compare(string f, longint e, longint a);
      if (e != a) begin
        fails++;
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, f, e, a);
      end
    endfunction

    function void check_result(out_item_t a);
      out_item_t e;
      if (wheel_cmd_q.size() == 0) begin
        fails++;
        $display("%0t: unexpected result, expected none, got %h", $time, a);
        return;
      end
      e = wheel_cmd_q.pop_front();
      compare("speed_front_left", e.speed_front_left, a.speed_front_left);
      compare("speed_front_right", e.speed_front_right, a.speed_front_right);
      compare("speed_back_left", e.speed_back_left, a.speed_back_left);
      compare("speed_back_right", e.speed_back_right, a.speed_back_right);
      compare("steer_front_left", e.steer_front_left, a.steer_front_left);
      compare("steer_front_right", e.steer_front_right, a.steer_front_right);
      compare("steer_back_left", e.steer_back_left, a.steer_back_left);
      compare("steer_back_right", e.steer_back_right, a.steer_back_right);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [3:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  int tx_idle = 10;
  int rx_idle = 64;
  logic hold_req = 1'b0;
  int hold_left = 0;
  wheel_scoreboard sb = new();

  swerve_drive_wheel_kinematics DUT (
    .clk, .rst_n, .in_valid, .in_ready, .in_data, .out_valid, .out_ready,
    .out_data, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  always #5 clk = ~clk;

  // Stall the result side at random, or for a long stretch on request
  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = 3000;
      hold_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else out_ready <= ($urandom_range(99) >= rx_idle);
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_data);
  end

  task automatic send_cmd(in_item_t c);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= c;
    do @(posedge clk); while (!in_ready);
    sb.note_request(c);
    @(negedge clk);
  endtask

  // Wait for every owed result, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.wheel_cmd_q.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [3:0] idx, logic [15:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.set_reg(idx, d);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic in_item_t make_cmd(int vx, int vy, int w, int hd);
    in_item_t c;
    c.target_vx = 16'(vx);
    c.target_vy = 16'(vy);
    c.target_turn_rate = 16'(w);
    c.heading = 16'(hd);
    return c;
  endfunction

  // Mostly plausible driving commands, some full-range noise
  function automatic in_item_t rand_cmd();
    if ($urandom_range(3) == 0)
      return make_cmd($urandom, $urandom, $urandom, $urandom);
    return make_cmd($urandom_range(7000) - 3500, $urandom_range(7000) - 3500,
                    $urandom_range(1000) - 500, $urandom);
  endfunction

  initial begin
    logic [15:0] cfg_set[6][4] = '{
      '{16'd3000, 16'd360, 16'd300, 16'd256},
      '{16'hFFFF, 16'hFFFF, 16'd4095, 16'hFFFF},
      '{16'd0, 16'd0, 16'd0, 16'd256},
      '{16'd3000, 16'd720, 16'd300, 16'd0},
      '{16'd500, 16'd90, 16'd4095, 16'd1000},
      '{16'hFFFF, 16'd360, 16'd150, 16'd256}};
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes, stillness, limits and headings
    send_cmd(make_cmd(0, 0, 0, 0));
    send_cmd(make_cmd(1000, 0, 0, 0));
    send_cmd(make_cmd(-1000, 0, 0, 0));
    send_cmd(make_cmd(0, 1000, 0, 16'h4000));
    send_cmd(make_cmd(0, -1000, 0, 16'h8000));
    send_cmd(make_cmd(32767, 32767, 32767, 16'hFFFF));
    send_cmd(make_cmd(-32768, -32768, -32768, 0));
    send_cmd(make_cmd(32767, -32768, 0, 16'h2000));
    send_cmd(make_cmd(0, 0, 360, 0));
    send_cmd(make_cmd(0, 0, -360, 0));
    send_cmd(make_cmd(0, 0, 5000, 0));
    send_cmd(make_cmd(2999, 0, 0, 16'hC000));
    send_cmd(make_cmd(3000, 1, 0, 0));
    send_cmd(make_cmd(-2121, 2122, 100, 16'h6000));
    send_cmd(make_cmd(0, 0, 0, 16'h1234));
    send_cmd(make_cmd(500, 500, -200, 16'hA000));
    send_cmd(make_cmd(-500, 500, 200, 16'h7FFF));
    send_cmd(make_cmd(1, 0, 0, 0));

    for (int p = 0; p < 6; p++) begin
      settle();
      tx_idle = (p < 2) ? 10 : (p < 4) ? 64 : 0;
      rx_idle = (p < 2) ? 64 : (p < 4) ? 10 : 0;
      if (p > 0) begin
        write_reg(CFG_MAX_LIN, cfg_set[p][0]);
        write_reg(CFG_MAX_TURN, cfg_set[p][1]);
        write_reg(CFG_RADIUS, cfg_set[p][2]);
        write_reg(CFG_RPM_GAIN, cfg_set[p][3]);
      end
      if (p == 5) write_reg(CFG_UNUSED, 16'h0000);
      // Back up the block with a long result stall
      if (p == 1) hold_req = 1'b1;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) send_cmd(rand_cmd());
    end

    settle();
    if (sb.fails == 0) $display("** swerve_drive_wheel_kinematics: PASSED **");
    else $display("** swerve_drive_wheel_kinematics: FAILED **");
    $finish;
  end

  initial begin
    #50000000;
    $display("** swerve_drive_wheel_kinematics: FAILED **");
    $finish;
  end
endmodule
